// File: rtl/core/besc_pkg.sv
// Shared constants and types for the body Euler step and escape check core.
`default_nettype none
package besc_pkg;

  // Operand slice width of the pipelined multipliers.
  localparam int CHUNK = 24;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_STEP  = 3'd0,
    CFG_CENTER_X   = 3'd1,
    CFG_CENTER_Y   = 3'd2,
    CFG_CENTER_Z   = 3'd3,
    CFG_TOTAL_MASS = 3'd4,
    CFG_GRAV_CONST = 3'd5
  } cfg_idx_t;

endpackage
`default_nettype wire

// File: rtl/core/besc_dly.sv
// Enabled delay line that keeps a payload aligned with the pipeline valid bits.
`default_nettype none
module besc_dly import besc_pkg::*; #(
  parameter int DW = 8,
  parameter int N  = 2
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [DW-1:0] d,
  output logic      [DW-1:0] q
);

  logic [DW-1:0] tap_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q = tap_r[N-1];

endmodule
`default_nettype wire

// File: rtl/core/besc_mul.sv
// Two-stage unsigned multiplier: registered slice products, then a registered sum.
`default_nettype none
module besc_mul import besc_pkg::*; #(
  parameter int AW = 48,
  parameter int BW = 48
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [AW-1:0]    a,
  input  wire logic [BW-1:0]    b,
  output logic      [AW+BW-1:0] p
);

  localparam int NA  = (AW + CHUNK - 1) / CHUNK;
  localparam int NB  = (BW + CHUNK - 1) / CHUNK;
  localparam int APW = NA * CHUNK;
  localparam int BPW = NB * CHUNK;
  localparam int SW  = APW + BPW;

  logic [APW-1:0]     a_pad;
  logic [BPW-1:0]     b_pad;
  logic [2*CHUNK-1:0] pp_r [NA][NB];
  logic [SW-1:0]      acc;
  logic [AW+BW-1:0]   p_r;

  assign a_pad = APW'(a);
  assign b_pad = BPW'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i][j] <= a_pad[i*CHUNK +: CHUNK] * b_pad[j*CHUNK +: CHUNK];
        end
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        acc = acc + (SW'(pp_r[i][j]) << (CHUNK * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= acc[AW+BW-1:0];
    end
  end

  assign p = p_r;

endmodule
`default_nettype wire

// File: rtl/core/besc_div.sv
// Pipelined restoring divider, one quotient bit per stage, signed saturated result.
`default_nettype none
module besc_div import besc_pkg::*; #(
  parameter int DW = 47
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [2*DW-1:0] num,
  input  wire logic [DW-1:0]   den,
  input  wire logic            neg,
  output logic      [DW:0]     quo
);

  localparam logic [DW:0] MINV = {1'b1, {DW{1'b0}}};
  localparam logic [DW:0] MAXV = ~MINV;

  logic [DW-1:0] rem_r [DW+1];
  logic [DW-1:0] lo_r  [DW+1];
  logic [DW-1:0] q_r   [DW+1];
  logic [DW-1:0] d_r   [DW+1];
  logic [DW:0]   ovf_r;
  logic [DW:0]   zero_r;
  logic [DW:0]   neg_r;
  logic [DW-1:0] rem_nxt [DW+1];
  logic [DW-1:0] q_nxt   [DW+1];
  logic [DW:0]   quo_r;

  // Step s shifts one numerator bit into the partial remainder.
  always_comb begin
    logic [DW:0] t;
    logic        ge;
    rem_nxt[0] = '0;
    q_nxt[0]   = '0;
    for (int s = 1; s <= DW; s++) begin
      t  = {rem_r[s-1], lo_r[s-1][DW-1]};
      ge = (t >= {1'b0, d_r[s-1]});
      rem_nxt[s] = ge ? DW'(t - {1'b0, d_r[s-1]}) : t[DW-1:0];
      q_nxt[s]   = {q_r[s-1][DW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // The quotient fits the word only when the upper numerator half is below the divisor.
      rem_r[0]  <= num[2*DW-1:DW];
      lo_r[0]   <= num[DW-1:0];
      q_r[0]    <= '0;
      d_r[0]    <= den;
      ovf_r[0]  <= (num[2*DW-1:DW] >= den);
      zero_r[0] <= (num == '0);
      neg_r[0]  <= neg;
      for (int s = 1; s <= DW; s++) begin
        rem_r[s]  <= rem_nxt[s];
        lo_r[s]   <= {lo_r[s-1][DW-2:0], 1'b0};
        q_r[s]    <= q_nxt[s];
        d_r[s]    <= d_r[s-1];
        ovf_r[s]  <= ovf_r[s-1];
        zero_r[s] <= zero_r[s-1];
        neg_r[s]  <= neg_r[s-1];
      end
      if (zero_r[DW]) begin
        quo_r <= '0;
      end else if (ovf_r[DW]) begin
        quo_r <= neg_r[DW] ? MINV : MAXV;
      end else begin
        quo_r <= neg_r[DW] ? (~{1'b0, q_r[DW]} + 1'b1) : {1'b0, q_r[DW]};
      end
    end
  end

  assign quo = quo_r;

endmodule
`default_nettype wire

// File: rtl/core/besc_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module besc_sqrt import besc_pkg::*; #(
  parameter int NW = 48
) (
  input  wire logic            clk,
  input  wire logic            en,
  input  wire logic [2*NW-1:0] rad,
  output logic      [NW-1:0]   root
);

  logic [NW+1:0]   rem_r  [NW];
  logic [NW-1:0]   root_r [NW];
  logic [2*NW-1:0] rest_r [NW];
  logic [NW+1:0]   rem_nxt  [NW];
  logic [NW-1:0]   root_nxt [NW];

  always_comb begin
    logic [NW+1:0]   rem_s;
    logic [NW-1:0]   root_s;
    logic [2*NW-1:0] rest_s;
    logic [NW+3:0]   t;
    logic [NW+3:0]   trial;
    logic            ge;
    for (int s = 0; s < NW; s++) begin
      if (s == 0) begin
        rem_s  = '0;
        root_s = '0;
        rest_s = rad;
      end else begin
        rem_s  = rem_r[s-1];
        root_s = root_r[s-1];
        rest_s = rest_r[s-1];
      end
      t     = {rem_s, rest_s[2*NW-1:2*NW-2]};
      trial = (NW+4)'({root_s, 2'b01});
      ge    = (t >= trial);
      rem_nxt[s]  = ge ? (NW+2)'(t - trial) : t[NW+1:0];
      root_nxt[s] = {root_s[NW-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= rem_nxt[0];
      root_r[0] <= root_nxt[0];
      rest_r[0] <= {rad[2*NW-3:0], 2'b00};
      for (int s = 1; s < NW; s++) begin
        rem_r[s]  <= rem_nxt[s];
        root_r[s] <= root_nxt[s];
        rest_r[s] <= {rest_r[s-1][2*NW-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[NW-1];

endmodule
`default_nettype wire

// File: rtl/core/body_euler_step_escape_check_core.sv
// Top level: semi-implicit Euler step of one body per beat with escape detection.
//
//  channel | direction | handshake             | payload
//  in_     | input     | in_valid / in_stall   | alive, mass, force, velocity, position
//  out_    | output    | out_valid / out_stall | new velocity, new position, flags
//  cfg_    | input     | cfg_valid / cfg_ready | register index and write data
//
// One body enters per cycle while the output is not stalled.
// The latency is set by the force divider and the distance square root, each of
// which resolves one result bit per pipeline stage.
// Reset clears the valid bits and loads the register defaults; data carries no reset.
// A stalled output beat freezes the whole pipeline, so in_stall follows it.
`default_nettype none
module body_euler_step_escape_check_core import besc_pkg::*; #(
  parameter int FRAC_BITS = 24,
  parameter int WORD_BITS = 48
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_alive,
  input  wire logic        [WORD_BITS-2:0] in_body_mass,
  input  wire logic signed [WORD_BITS-1:0] in_force_x,
  input  wire logic signed [WORD_BITS-1:0] in_force_y,
  input  wire logic signed [WORD_BITS-1:0] in_force_z,
  input  wire logic signed [WORD_BITS-1:0] in_vel_x,
  input  wire logic signed [WORD_BITS-1:0] in_vel_y,
  input  wire logic signed [WORD_BITS-1:0] in_vel_z,
  input  wire logic signed [WORD_BITS-1:0] in_pos_x,
  input  wire logic signed [WORD_BITS-1:0] in_pos_y,
  input  wire logic signed [WORD_BITS-1:0] in_pos_z,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed      [WORD_BITS-1:0] out_new_vel_x,
  output logic signed      [WORD_BITS-1:0] out_new_vel_y,
  output logic signed      [WORD_BITS-1:0] out_new_vel_z,
  output logic signed      [WORD_BITS-1:0] out_new_pos_x,
  output logic signed      [WORD_BITS-1:0] out_new_pos_y,
  output logic signed      [WORD_BITS-1:0] out_new_pos_z,
  output logic                             out_escaping,
  output logic                             out_updated,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic        [CFG_IDX_W-1:0] cfg_index,
  input  wire logic        [WORD_BITS-1:0] cfg_data
);

  localparam int W     = WORD_BITS;
  localparam int F     = FRAC_BITS;
  localparam int UW    = W - 1;
  localparam int AQW   = 2 * W - F;
  localparam int ADW   = AQW + W;
  localparam int CW    = (ADW > 2 * W - 1) ? ADW : 2 * W - 1;
  localparam int TC    = W + 4;
  localparam int TOTAL = 2 * W + 15;
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] MAXV = ~MINV;

  function automatic logic [W-1:0] sat_add(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} + {b[W-1], b};
    sat_add = (s[W] != s[W-1]) ? (s[W] ? MINV : MAXV) : s[W-1:0];
  endfunction

  function automatic logic [W-1:0] sat_sub(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {a[W-1], a} - {b[W-1], b};
    sat_sub = (s[W] != s[W-1]) ? (s[W] ? MINV : MAXV) : s[W-1:0];
  endfunction

  function automatic logic [W-1:0] mag(input logic [W-1:0] x);
    mag = x[W-1] ? (~x + 1'b1) : x;
  endfunction

  // Configuration registers.
  logic [UW-1:0]       time_step_r;
  logic [2:0][W-1:0]   center_r;
  logic [UW-1:0]       total_mass_r;
  logic [UW-1:0]       grav_const_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r  <= UW'(16777);
      center_r     <= '0;
      total_mass_r <= '0;
      grav_const_r <= UW'(1) << F;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TIME_STEP:  time_step_r  <= cfg_data[UW-1:0];
        CFG_CENTER_X:   center_r[0]  <= cfg_data;
        CFG_CENTER_Y:   center_r[1]  <= cfg_data;
        CFG_CENTER_Z:   center_r[2]  <= cfg_data;
        CFG_TOTAL_MASS: total_mass_r <= cfg_data[UW-1:0];
        CFG_GRAV_CONST: grav_const_r <= cfg_data[UW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  // Pipeline control.
  logic [TOTAL-1:0] vld_r;
  logic             en;

  assign en       = !(vld_r[TOTAL-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOTAL-2:0], in_valid};
    end
  end

  logic [2:0][W-1:0] f_in, v_in, x_in;
  assign f_in = {in_force_z, in_force_y, in_force_x};
  assign v_in = {in_vel_z, in_vel_y, in_vel_x};
  assign x_in = {in_pos_z, in_pos_y, in_pos_x};

  // 2*G*M must stay static while bodies are in flight; the block itself does not enforce this.
  logic [2*UW-1:0] gm;
  logic [2*W-2:0]  gm2;
  besc_mul #(.AW(UW), .BW(UW)) u_mul_gm (
    .clk(clk), .en(1'b1), .a(grav_const_r), .b(total_mass_r), .p(gm)
  );
  assign gm2 = {gm, 1'b0};

  // Force scaling and division by the body mass.
  logic [2:0][W-1:0]   f_mag;
  logic [2:0][2*W-2:0] p_f;
  logic [2:0]          fneg_d;
  logic [UW-1:0]       mass_d;
  logic [2:0][W-1:0]   dv;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      f_mag[k] = mag(f_in[k]);
    end
  end

  besc_dly #(.DW(3), .N(2)) u_dly_fneg (
    .clk(clk), .en(en), .d({f_in[2][W-1], f_in[1][W-1], f_in[0][W-1]}), .q(fneg_d)
  );
  besc_dly #(.DW(UW), .N(2)) u_dly_mass (
    .clk(clk), .en(en), .d(in_body_mass), .q(mass_d)
  );

  for (genvar k = 0; k < 3; k++) begin : g_force
    besc_mul #(.AW(UW), .BW(W)) u_mul_f (
      .clk(clk), .en(en), .a(time_step_r), .b(f_mag[k]), .p(p_f[k])
    );
    besc_div #(.DW(UW)) u_div (
      .clk(clk), .en(en), .num(p_f[k][2*UW-1:0]), .den(mass_d), .neg(fneg_d[k]),
      .quo(dv[k])
    );
  end

  // Velocity update.
  logic [2:0][W-1:0] v_d;
  logic              alive_d;
  logic [2:0][W-1:0] vn_r;
  logic              alive_c_r;

  besc_dly #(.DW(3*W), .N(TC-1)) u_dly_v (.clk(clk), .en(en), .d(v_in), .q(v_d));
  besc_dly #(.DW(1), .N(TC-1)) u_dly_alive (.clk(clk), .en(en), .d(in_alive), .q(alive_d));

  always_ff @(posedge clk) begin
    if (en) begin
      alive_c_r <= alive_d;
      for (int k = 0; k < 3; k++) begin
        vn_r[k] <= alive_d ? sat_add(v_d[k], dv[k]) : v_d[k];
      end
    end
  end

  // Position increment and squared speed.
  logic [2:0][W-1:0]   vn_mag;
  logic [2:0][2*W-2:0] p_vdt;
  logic [2:0][2*W-1:0] p_vv;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vn_mag[k] = mag(vn_r[k]);
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_vel
    besc_mul #(.AW(UW), .BW(W)) u_mul_vdt (
      .clk(clk), .en(en), .a(time_step_r), .b(vn_mag[k]), .p(p_vdt[k])
    );
    besc_mul #(.AW(W), .BW(W)) u_mul_vv (
      .clk(clk), .en(en), .a(vn_mag[k]), .b(vn_mag[k]), .p(p_vv[k])
    );
  end

  logic [3*W:0]      vn_c_d;
  logic [2:0][W-1:0] vn_e1_r, vn_e2_r, vn_e3_r;
  logic              alive_e1_r, alive_e2_r;
  logic [2:0][W-1:0] inc_r;
  logic [2:0][W-1:0] x_d;
  logic [2:0][W-1:0] xn_r;
  logic [2:0][W-1:0] r_r;

  besc_dly #(.DW(3*W+1), .N(2)) u_dly_vn (
    .clk(clk), .en(en), .d({alive_c_r, vn_r}), .q(vn_c_d)
  );
  besc_dly #(.DW(3*W), .N(TC+3)) u_dly_x (.clk(clk), .en(en), .d(x_in), .q(x_d));

  always_ff @(posedge clk) begin
    logic [2*W-2:0] incm;
    logic [W-1:0]   m;
    logic           neg;
    if (en) begin
      vn_e1_r    <= vn_c_d[3*W-1:0];
      alive_e1_r <= vn_c_d[3*W];
      vn_e2_r    <= vn_e1_r;
      alive_e2_r <= alive_e1_r;
      vn_e3_r    <= vn_e2_r;
      for (int k = 0; k < 3; k++) begin
        incm = p_vdt[k] >> F;
        m    = incm[W-1:0];
        neg  = vn_c_d[k*W + W - 1];
        if (|incm[2*W-2:UW]) begin
          inc_r[k] <= neg ? MINV : MAXV;
        end else begin
          inc_r[k] <= neg ? (~m + 1'b1) : m;
        end
        xn_r[k] <= alive_e1_r ? sat_add(x_d[k], inc_r[k]) : x_d[k];
        r_r[k]  <= sat_sub(xn_r[k], center_r[k]);
      end
    end
  end

  // Distance and direction products.
  logic [2:0][W-1:0]   r_mag, v3_mag;
  logic [2:0][2*W-1:0] p_rr, p_vr, p_vv_d;
  logic [2:0]          same_sign, same_d;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      r_mag[k]     = mag(r_r[k]);
      v3_mag[k]    = mag(vn_e3_r[k]);
      same_sign[k] = (vn_e3_r[k][W-1] == r_r[k][W-1]);
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_dist
    besc_mul #(.AW(W), .BW(W)) u_mul_rr (
      .clk(clk), .en(en), .a(r_mag[k]), .b(r_mag[k]), .p(p_rr[k])
    );
    besc_mul #(.AW(W), .BW(W)) u_mul_vr (
      .clk(clk), .en(en), .a(v3_mag[k]), .b(r_mag[k]), .p(p_vr[k])
    );
  end

  besc_dly #(.DW(6*W), .N(5)) u_dly_vv (.clk(clk), .en(en), .d(p_vv), .q(p_vv_d));
  besc_dly #(.DW(3), .N(2)) u_dly_sign (.clk(clk), .en(en), .d(same_sign), .q(same_d));

  logic [2*W-1:0] s2_r, r2_r, dpos_r, dneg_r;
  logic           dot_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_r   <= p_vv_d[0] + p_vv_d[1] + p_vv_d[2];
      r2_r   <= p_rr[0] + p_rr[1] + p_rr[2];
      dpos_r <= (same_d[0] ? p_vr[0] : '0) + (same_d[1] ? p_vr[1] : '0)
              + (same_d[2] ? p_vr[2] : '0);
      dneg_r <= (same_d[0] ? '0 : p_vr[0]) + (same_d[1] ? '0 : p_vr[1])
              + (same_d[2] ? '0 : p_vr[2]);
      dot_r  <= (dpos_r > dneg_r);
    end
  end

  // Escape test: floor(s2 / 2^F) > floor(2GM / d) is the same as (s2 >> F) * d > 2GM.
  logic [W-1:0]   dist_root;
  logic [AQW-1:0] a_q, a_d;
  logic [ADW-1:0] p_ad;
  logic           dot_d, dnz_d;

  assign a_q = AQW'(s2_r >> F);

  besc_sqrt #(.NW(W)) u_sqrt (.clk(clk), .en(en), .rad(r2_r), .root(dist_root));
  besc_dly #(.DW(AQW), .N(W)) u_dly_a (.clk(clk), .en(en), .d(a_q), .q(a_d));
  besc_dly #(.DW(1), .N(W+1)) u_dly_dot (.clk(clk), .en(en), .d(dot_r), .q(dot_d));
  besc_dly #(.DW(1), .N(2)) u_dly_dnz (.clk(clk), .en(en), .d(dist_root != '0), .q(dnz_d));
  besc_mul #(.AW(AQW), .BW(W)) u_mul_ad (
    .clk(clk), .en(en), .a(a_d), .b(dist_root), .p(p_ad)
  );

  logic [6*W:0]      res_d;
  logic [2:0][W-1:0] vel_o_r, pos_o_r;
  logic              esc_r, upd_r;

  besc_dly #(.DW(6*W+1), .N(W+6)) u_dly_res (
    .clk(clk), .en(en), .d({alive_e2_r, xn_r, vn_e2_r}), .q(res_d)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      vel_o_r <= res_d[3*W-1:0];
      pos_o_r <= res_d[6*W-1:3*W];
      upd_r   <= res_d[6*W];
      esc_r   <= res_d[6*W] && dnz_d && dot_d && (CW'(p_ad) > CW'(gm2));
    end
  end

  assign out_valid     = vld_r[TOTAL-1];
  assign out_new_vel_x = vel_o_r[0];
  assign out_new_vel_y = vel_o_r[1];
  assign out_new_vel_z = vel_o_r[2];
  assign out_new_pos_x = pos_o_r[0];
  assign out_new_pos_y = pos_o_r[1];
  assign out_new_pos_z = pos_o_r[2];
  assign out_escaping  = esc_r;
  assign out_updated   = upd_r;

  a_esc_live: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_escaping |-> out_updated)
    else $error("escape flagged on a body that was not integrated");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(vld_r))
    else $error("pipeline moved while the output beat was stalled");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> vld_r == '0)
    else $error("valid bits not cleared by reset");

endmodule
`default_nettype wire
